### rtl/core/msrrf_pkg.sv
// Package with the slot map, reset defaults and shared types of the MSR register file.
`default_nettype none

package msrrf_pkg;

   localparam int NUM_MSR = 16;
   localparam int SLOT_W  = 4;
   localparam int NUM_MON = 11;
   localparam int MON_W   = 4;

   localparam logic [1:0] KIND_READ   = 2'd0;
   localparam logic [1:0] KIND_WRITE  = 2'd1;
   localparam logic [1:0] KIND_SWAP   = 2'd2;
   localparam logic [1:0] KIND_DETECT = 2'd3;

   localparam logic [SLOT_W-1:0] S_APIC    = 4'd0;
   localparam logic [SLOT_W-1:0] S_SYSCS   = 4'd1;
   localparam logic [SLOT_W-1:0] S_SYSESP  = 4'd2;
   localparam logic [SLOT_W-1:0] S_SYSEIP  = 4'd3;
   localparam logic [SLOT_W-1:0] S_DBGCTL  = 4'd4;
   localparam logic [SLOT_W-1:0] S_PAT     = 4'd5;
   localparam logic [SLOT_W-1:0] S_MTRRDEF = 4'd6;
   localparam logic [SLOT_W-1:0] S_EFER    = 4'd7;
   localparam logic [SLOT_W-1:0] S_STAR    = 4'd8;
   localparam logic [SLOT_W-1:0] S_LSTAR   = 4'd9;
   localparam logic [SLOT_W-1:0] S_CSTAR   = 4'd10;
   localparam logic [SLOT_W-1:0] S_SFMASK  = 4'd11;
   localparam logic [SLOT_W-1:0] S_FSBASE  = 4'd12;
   localparam logic [SLOT_W-1:0] S_GSBASE  = 4'd13;
   localparam logic [SLOT_W-1:0] S_KGSBASE = 4'd14;
   localparam logic [SLOT_W-1:0] S_TSCAUX  = 4'd15;

   localparam logic [63:0] EFER_LMA      = 64'h0000_0000_0000_0400;
   localparam logic [63:0] EFER_WR_MASK  = 64'h0000_0000_0000_0901;
   localparam logic [63:0] APIC_BSP      = 64'h0000_0000_0000_0100;
   localparam logic [63:0] APIC_WR_MASK  = 64'h0000_000F_FFFF_F800;
   localparam logic [63:0] LOW16_MASK    = 64'h0000_0000_0000_FFFF;
   localparam logic [63:0] LOW32_MASK    = 64'h0000_0000_FFFF_FFFF;
   localparam logic [63:0] MTRRDEF_MASK  = 64'h0000_0000_0000_0CFF;

   typedef struct packed {
      logic              hit;
      logic [SLOT_W-1:0] slot;
   } slot_hit_type;

   typedef struct packed {
      logic        ok;
      logic [63:0] value;
   } wr_result_type;

   function automatic logic [31:0] msr_number(input logic [SLOT_W-1:0] slot);
      logic [31:0] num;
      unique case (slot)
         S_APIC:    num = 32'h0000_001B;
         S_SYSCS:   num = 32'h0000_0174;
         S_SYSESP:  num = 32'h0000_0175;
         S_SYSEIP:  num = 32'h0000_0176;
         S_DBGCTL:  num = 32'h0000_01D9;
         S_PAT:     num = 32'h0000_0277;
         S_MTRRDEF: num = 32'h0000_02FF;
         S_EFER:    num = 32'hC000_0080;
         S_STAR:    num = 32'hC000_0081;
         S_LSTAR:   num = 32'hC000_0082;
         S_CSTAR:   num = 32'hC000_0083;
         S_SFMASK:  num = 32'hC000_0084;
         S_FSBASE:  num = 32'hC000_0100;
         S_GSBASE:  num = 32'hC000_0101;
         S_KGSBASE: num = 32'hC000_0102;
         S_TSCAUX:  num = 32'hC000_0103;
      endcase
      return num;
   endfunction

   function automatic logic [63:0] msr_default(input logic [SLOT_W-1:0] slot);
      logic [63:0] val;
      unique case (slot)
         S_APIC:    val = 64'h0000_0000_FEE0_0900;
         S_SYSCS:   val = 64'h0000_0000_0000_0010;
         S_SYSESP:  val = 64'hFFFF_F800_0020_1000;
         S_SYSEIP:  val = 64'hFFFF_F800_0020_0200;
         S_DBGCTL:  val = 64'h0000_0000_0000_0000;
         S_PAT:     val = 64'h0007_0406_0007_0406;
         S_MTRRDEF: val = 64'h0000_0000_0000_0C06;
         S_EFER:    val = 64'h0000_0000_0000_0D01;
         S_STAR:    val = 64'h0023_0010_0000_0000;
         S_LSTAR:   val = 64'hFFFF_F800_0020_0000;
         S_CSTAR:   val = 64'hFFFF_F800_0020_0100;
         S_SFMASK:  val = 64'h0000_0000_0004_7700;
         S_FSBASE:  val = 64'h0000_0000_0000_0000;
         S_GSBASE:  val = 64'hFFFF_F780_0000_0000;
         S_KGSBASE: val = 64'h0000_0000_7FFE_0000;
         S_TSCAUX:  val = 64'h0000_0000_0000_0000;
      endcase
      return val;
   endfunction

   function automatic logic [SLOT_W-1:0] mon_slot(input logic [MON_W-1:0] ptr);
      logic [SLOT_W-1:0] slot;
      unique case (ptr)
         4'd0:    slot = S_LSTAR;
         4'd1:    slot = S_CSTAR;
         4'd2:    slot = S_STAR;
         4'd3:    slot = S_SFMASK;
         4'd4:    slot = S_EFER;
         4'd5:    slot = S_SYSEIP;
         4'd6:    slot = S_SYSESP;
         4'd7:    slot = S_SYSCS;
         4'd8:    slot = S_DBGCTL;
         4'd9:    slot = S_GSBASE;
         4'd10:   slot = S_KGSBASE;
         default: slot = S_LSTAR;
      endcase
      return slot;
   endfunction

   function automatic slot_hit_type find_slot(input logic [31:0] idx);
      slot_hit_type res;
      res = '0;
      for (int i = 0; i < NUM_MSR; i++) begin
         if (msr_number(SLOT_W'(i)) == idx) begin
            res.hit  = 1'b1;
            res.slot = SLOT_W'(i);
         end
      end
      return res;
   endfunction

endpackage

`default_nettype wire

### rtl/core/msr_register_file_core.sv
// Top level of the model-specific register file with its sequencer and result register.
//
// The request channel carries one access per beat: the kind in req_tuser and the MSR
// number and write value in req_tdata. The response channel returns result beats, with
// rsp_tlast on the final beat caused by a request.
// For a read, write or GS base swap the beat is accepted and the slot decoded, then the
// execute step reads the register array through its single read port, applies the
// write checks and loads the result register.
// A detect request walks the eleven monitored registers through the same read port and
// one 64-bit comparator, one register a cycle while the receiver keeps up, holding
// back the latest difference so that the final beat can carry tlast.
// Requests are taken only while the sequencer is idle; a finished result may still be
// waiting in the result register, so a new beat is accepted under a stalled receiver.
// A stalled receiver holds the execute step or the walk whenever a further beat must
// be loaded into the occupied result register.
// Reset restores every register to its architectural default and clears both
// saturating access counters and the sequencer.
`default_nettype none

module msr_register_file_core
   import msrrf_pkg::*;
#(
   parameter int COUNT_WIDTH = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // msr_index [31:0], write_data [95:32]
   input  wire logic [95:0]  req_tdata,
   // kind [1:0]
   input  wire logic [1:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // read_data [63:0], mod_index [95:64], default_value [159:96],
   // present_value [223:160], reads_done [255:224], writes_done [287:256]
   output logic [287:0]      rsp_tdata,
   // ok [0], mod_found [1]
   output logic [1:0]        rsp_tuser,
   output logic              rsp_tlast
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_EXEC  = 2'd1;
   localparam logic [1:0] ST_WALK  = 2'd2;
   localparam logic [1:0] ST_FLUSH = 2'd3;

   typedef struct packed {
      logic        ok;
      logic [63:0] read_data;
      logic        mod_found;
      logic [31:0] mod_index;
      logic [63:0] default_value;
      logic [63:0] present_value;
      logic        last;
      logic [31:0] reads_done;
      logic [31:0] writes_done;
   } rsp_type;

   logic [63:0]            msr_ff [NUM_MSR];
   logic [1:0]             state_ff, state_in;
   logic [1:0]             kind_ff, kind_in;
   logic                   hit_ff, hit_in;
   logic [SLOT_W-1:0]      slot_ff, slot_in;
   logic [63:0]            data_ff, data_in;
   logic [MON_W-1:0]       walk_ptr_ff, walk_ptr_in;
   logic                   pend_valid_ff, pend_valid_in;
   logic [SLOT_W-1:0]      pend_slot_ff, pend_slot_in;
   logic [63:0]            pend_value_ff, pend_value_in;
   logic [COUNT_WIDTH-1:0] read_count_ff, read_count_in;
   logic [COUNT_WIDTH-1:0] write_count_ff, write_count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   slot_hit_type           lookup;
   logic [SLOT_W-1:0]      rd_slot;
   logic [63:0]            rd_value;
   logic                   differ;
   logic                   out_free;
   logic                   emit;
   logic                   wr_en;
   logic                   swap_en;
   wr_result_type          wr_result;

   assign lookup   = find_slot(req_tdata[31:0]);
   assign rd_slot  = (state_ff == ST_WALK) ? mon_slot(walk_ptr_ff) : slot_ff;
   assign rd_value = msr_ff[rd_slot];
   assign differ   = (rd_value != msr_default(rd_slot));
   assign out_free = !rsp_valid_ff || rsp_tready;

   msrrf_write_unit u_write_unit (
      .slot       (slot_ff),
      .prev_value (rd_value),
      .write_data (data_ff),
      .result     (wr_result)
   );

   always_comb begin
      state_in       = state_ff;
      kind_in        = kind_ff;
      hit_in         = hit_ff;
      slot_in        = slot_ff;
      data_in        = data_ff;
      walk_ptr_in    = walk_ptr_ff;
      pend_valid_in  = pend_valid_ff;
      pend_slot_in   = pend_slot_ff;
      pend_value_in  = pend_value_ff;
      read_count_in  = read_count_ff;
      write_count_in = write_count_ff;
      emit           = 1'b0;
      wr_en          = 1'b0;
      swap_en        = 1'b0;
      rsp_in         = '0;
      rsp_in.ok      = 1'b1;
      rsp_in.last    = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               kind_in       = req_tuser;
               hit_in        = lookup.hit;
               slot_in       = lookup.slot;
               data_in       = req_tdata[95:32];
               walk_ptr_in   = '0;
               pend_valid_in = 1'b0;
               state_in      = (req_tuser == KIND_DETECT) ? ST_WALK : ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
               unique case (kind_ff)
                  KIND_READ: begin
                     rsp_in.ok = hit_ff;
                     if (hit_ff) begin
                        rsp_in.read_data = rd_value;
                        if (read_count_ff != '1) begin
                           read_count_in = read_count_ff + COUNT_WIDTH'(1);
                        end
                     end
                  end
                  KIND_WRITE: begin
                     rsp_in.ok = hit_ff && wr_result.ok;
                     if (hit_ff && wr_result.ok) begin
                        wr_en = 1'b1;
                        if (write_count_ff != '1) begin
                           write_count_in = write_count_ff + COUNT_WIDTH'(1);
                        end
                     end
                  end
                  KIND_SWAP: begin
                     swap_en = 1'b1;
                  end
                  KIND_DETECT: begin
                     rsp_in.ok = 1'b1;
                  end
               endcase
            end
         end
         ST_WALK: begin
            if (!(differ && pend_valid_ff && !out_free)) begin
               if (differ) begin
                  if (pend_valid_ff) begin
                     emit                 = 1'b1;
                     rsp_in.mod_found     = 1'b1;
                     rsp_in.mod_index     = msr_number(pend_slot_ff);
                     rsp_in.default_value = msr_default(pend_slot_ff);
                     rsp_in.present_value = pend_value_ff;
                     rsp_in.last          = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_slot_in  = rd_slot;
                  pend_value_in = rd_value;
               end
               walk_ptr_in = walk_ptr_ff + MON_W'(1);
               if (walk_ptr_ff == MON_W'(NUM_MON - 1)) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
               if (pend_valid_ff) begin
                  rsp_in.mod_found     = 1'b1;
                  rsp_in.mod_index     = msr_number(pend_slot_ff);
                  rsp_in.default_value = msr_default(pend_slot_ff);
                  rsp_in.present_value = pend_value_ff;
               end
            end
         end
      endcase

      rsp_in.reads_done  = 32'(read_count_in);
      rsp_in.writes_done = 32'(write_count_in);
      rsp_valid_in       = emit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_MSR; i++) begin
            msr_ff[i] <= msr_default(SLOT_W'(i));
         end
      end else if (swap_en) begin
         msr_ff[S_GSBASE]  <= msr_ff[S_KGSBASE];
         msr_ff[S_KGSBASE] <= msr_ff[S_GSBASE];
      end else if (wr_en) begin
         msr_ff[slot_ff] <= wr_result.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         pend_valid_ff  <= 1'b0;
         walk_ptr_ff    <= '0;
         read_count_ff  <= '0;
         write_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         pend_valid_ff  <= pend_valid_in;
         walk_ptr_ff    <= walk_ptr_in;
         read_count_ff  <= read_count_in;
         write_count_ff <= write_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      hit_ff        <= hit_in;
      slot_ff       <= slot_in;
      data_ff       <= data_in;
      pend_slot_ff  <= pend_slot_in;
      pend_value_ff <= pend_value_in;
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.writes_done, rsp_ff.reads_done, rsp_ff.present_value,
                        rsp_ff.default_value, rsp_ff.mod_index, rsp_ff.read_data};
   assign rsp_tuser  = {rsp_ff.mod_found, rsp_ff.ok};
   assign rsp_tlast  = rsp_ff.last;

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> walk_ptr_ff < MON_W'(NUM_MON))
      else $error("walk pointer beyond the monitored registers");

   a_found_is_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.mod_found |-> rsp_ff.ok)
      else $error("modification result without ok");

   a_reads_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> read_count_ff >= $past(read_count_ff))
      else $error("read counter decreased");

   a_read_count_with_result: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$stable(read_count_ff) |-> rsp_valid_ff && rsp_ff.ok)
      else $error("read counter moved without an accepted result");

   a_write_count_with_result: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$stable(write_count_ff) |-> rsp_valid_ff && rsp_ff.ok)
      else $error("write counter moved without an accepted result");

endmodule

`default_nettype wire

### rtl/core/msrrf_write_unit.sv
// Write masking and value checks applied to a write before it reaches the register array.
`default_nettype none

module msrrf_write_unit
   import msrrf_pkg::*;
(
   input  wire logic [SLOT_W-1:0] slot,
   input  wire logic [63:0]       prev_value,
   input  wire logic [63:0]       write_data,
   output wr_result_type          result
);

   function automatic logic mem_type_ok(input logic [7:0] t);
      return (t[7:3] == 5'd0) && (t[2:1] != 2'b01);
   endfunction

   logic pat_ok;
   logic canonical;

   always_comb begin
      pat_ok = 1'b1;
      for (int i = 0; i < 8; i++) begin
         if (!mem_type_ok(write_data[i*8 +: 8])) begin
            pat_ok = 1'b0;
         end
      end
   end

   assign canonical = (write_data[63:47] == 17'h00000) || (write_data[63:47] == 17'h1FFFF);

   always_comb begin
      result.ok    = 1'b1;
      result.value = write_data;
      unique case (slot)
         S_EFER: begin
            result.value = (prev_value & EFER_LMA) | (write_data & EFER_WR_MASK);
         end
         S_DBGCTL, S_SYSCS: begin
            result.value = write_data & LOW16_MASK;
         end
         S_MTRRDEF: begin
            result.value = write_data & MTRRDEF_MASK;
            result.ok    = mem_type_ok(write_data[7:0]);
         end
         S_APIC: begin
            result.value = (write_data & APIC_WR_MASK) | (prev_value & APIC_BSP);
         end
         S_PAT: begin
            result.ok = pat_ok;
         end
         S_TSCAUX: begin
            result.value = write_data & LOW32_MASK;
         end
         S_LSTAR, S_CSTAR, S_FSBASE, S_GSBASE, S_KGSBASE, S_SYSESP, S_SYSEIP: begin
            result.ok = canonical;
         end
         S_STAR, S_SFMASK: begin
            result.value = write_data;
         end
      endcase
   end

endmodule

`default_nettype wire
